// ===== sv/qsu_pkg.sv =====
package qsu_pkg;

   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_BS     = 8'h08;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   typedef enum logic [1:0] {
      PH_OPEN  = 2'd0,
      PH_EMPTY = 2'd1,
      PH_HELD  = 2'd2,
      PH_ESC   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_present;
      logic       string_done;
      logic       bad_format;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    res0;
      rsp_type    res1;
   } pair_type;

   typedef struct packed {
      logic       known;
      logic [7:0] value;
   } esc_type;

   function automatic esc_type map_escape(input logic [7:0] c);
      esc_type e;
      e.known = 1'b1;
      e.value = c;
      case (c)
         CHAR_N:      e.value = CHAR_LF;
         CHAR_T:      e.value = CHAR_TAB;
         CHAR_R:      e.value = CHAR_CR;
         CHAR_B:      e.value = CHAR_BS;
         CHAR_BSLASH: e.value = CHAR_BSLASH;
         CHAR_QUOTE:  e.value = CHAR_QUOTE;
         CHAR_SQUOTE: e.value = CHAR_SQUOTE;
         default:     e.known = 1'b0;
      endcase
      return e;
   endfunction

   function automatic rsp_type char_rsp(input logic [7:0] c);
      rsp_type r;
      r.out_char     = c;
      r.char_present = 1'b1;
      r.string_done  = 1'b0;
      r.bad_format   = 1'b0;
      return r;
   endfunction

   function automatic rsp_type end_rsp(input logic bad);
      rsp_type r;
      r.out_char     = 8'h00;
      r.char_present = 1'b0;
      r.string_done  = 1'b1;
      r.bad_format   = bad;
      return r;
   endfunction

endpackage

// ===== sv/qsu_decode.sv =====
module qsu_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         in_char,
   input  logic               is_final,
   output qsu_pkg::pair_type  pair
);

   qsu_pkg::phase_type phase_ff, phase_in;
   logic               format_error_ff, format_error_in;
   logic [7:0]         held_char_ff, held_char_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= qsu_pkg::PH_OPEN;
         format_error_ff <= 1'b0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         format_error_ff <= format_error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_char_ff <= held_char_in;
      end
   end

   always_comb begin
      qsu_pkg::esc_type esc;
      logic             not_quote;
      esc             = qsu_pkg::map_escape(in_char);
      not_quote       = (in_char != qsu_pkg::CHAR_QUOTE);
      phase_in        = phase_ff;
      format_error_in = format_error_ff;
      held_char_in    = held_char_ff;
      pair.count      = 2'd0;
      pair.res0       = qsu_pkg::end_rsp(1'b0);
      pair.res1       = qsu_pkg::end_rsp(1'b0);
      if (is_final) begin
         phase_in        = qsu_pkg::PH_OPEN;
         format_error_in = 1'b0;
         unique case (phase_ff)
            qsu_pkg::PH_OPEN: begin
               pair.count = 2'd1;
               pair.res0  = qsu_pkg::end_rsp(not_quote);
            end
            qsu_pkg::PH_EMPTY: begin
               pair.count = 2'd1;
               pair.res0  = qsu_pkg::end_rsp(format_error_ff | not_quote);
            end
            qsu_pkg::PH_HELD: begin
               pair.count = 2'd2;
               pair.res0  = qsu_pkg::char_rsp(held_char_ff);
               pair.res1  = qsu_pkg::end_rsp(format_error_ff | not_quote);
            end
            default: begin
               pair.count = 2'd2;
               pair.res0  = qsu_pkg::char_rsp(qsu_pkg::CHAR_BSLASH);
               pair.res1  = qsu_pkg::end_rsp(format_error_ff | not_quote);
            end
         endcase
      end else begin
         unique case (phase_ff) inside
            qsu_pkg::PH_OPEN: begin
               format_error_in = not_quote;
               phase_in        = qsu_pkg::PH_EMPTY;
            end
            qsu_pkg::PH_EMPTY, qsu_pkg::PH_HELD: begin
               if (phase_ff == qsu_pkg::PH_HELD) begin
                  pair.count = 2'd1;
                  pair.res0  = qsu_pkg::char_rsp(held_char_ff);
               end
               if (in_char == qsu_pkg::CHAR_BSLASH) begin
                  phase_in = qsu_pkg::PH_ESC;
               end else begin
                  held_char_in = in_char;
                  phase_in     = qsu_pkg::PH_HELD;
               end
            end
            default: begin
               phase_in = qsu_pkg::PH_EMPTY;
               if (esc.known) begin
                  pair.count = 2'd1;
                  pair.res0  = qsu_pkg::char_rsp(esc.value);
               end else begin
                  pair.count = 2'd2;
                  pair.res0  = qsu_pkg::char_rsp(qsu_pkg::CHAR_BSLASH);
                  pair.res1  = qsu_pkg::char_rsp(in_char);
               end
            end
         endcase
      end
   end

endmodule

// ===== sv/qsu_rsp_fifo.sv =====
module qsu_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  qsu_pkg::pair_type pair,
   output logic              room,
   output logic              out_valid,
   input  logic              out_ready,
   output qsu_pkg::rsp_type  out_data
);

   qsu_pkg::rsp_type                mem [qsu_pkg::FIFO_DEPTH];
   logic [qsu_pkg::FIFO_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [qsu_pkg::FIFO_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [qsu_pkg::FIFO_AW:0]       count_ff, count_in;
   logic [1:0]                      n_push;
   logic                            pop;

   assign n_push    = push ? pair.count : 2'd0;
   assign pop       = out_valid & out_ready;
   assign out_valid = (count_ff != '0);
   assign out_data  = mem[rd_ptr_ff];
   assign room      = (count_ff <= (qsu_pkg::FIFO_AW+1)'(qsu_pkg::FIFO_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + qsu_pkg::FIFO_AW'(n_push);
      rd_ptr_in = rd_ptr_ff + qsu_pkg::FIFO_AW'(pop);
      count_in  = count_ff + (qsu_pkg::FIFO_AW+1)'(n_push)
                  - (qsu_pkg::FIFO_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         mem[wr_ptr_ff] <= pair.res0;
      end
      if (n_push == 2'd2) begin
         mem[wr_ptr_ff + qsu_pkg::FIFO_AW'(1)] <= pair.res1;
      end
   end

endmodule

// ===== sv/quoted_string_unescaper.sv =====
// Decodes a double-quoted string literal, one byte per req transaction.
// req: tdata = source byte, tlast = final byte of the literal.
// rsp: tdata = decoded byte, tuser[0] = byte present, tuser[1] = bad format,
//      tlast = end marker of the literal (no byte, carries the format flag).
// Quotes are dropped and known escapes collapse to one byte; each plain
// body byte is held until the next byte shows it is not the closing quote,
// so such a byte appears on rsp one transaction later than it arrives.
// Throughput: one req transaction per cycle while the queue has room; a
// transaction yields zero, one or two results, written into a 4-entry
// result queue in the same cycle; rsp shows the oldest queued result.
// req_tready is high while the queue has room for two results, so a rsp
// stall fills the queue and then backs up req without losing anything.
// Reset empties the queue and returns the decoder to waiting for the
// opening quote; the end marker does the same for the decoder.
module quoted_string_unescaper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_char
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [1:0] rsp_tuser,   // [0] char_present, [1] bad_format
   output logic       rsp_tlast
);

   qsu_pkg::pair_type pair;
   qsu_pkg::rsp_type  head;
   logic              accept;
   logic              room;

   assign req_tready = room;
   assign accept     = req_tvalid & room;

   qsu_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_char  (req_tdata),
      .is_final (req_tlast),
      .pair     (pair)
   );

   qsu_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .pair      (pair),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   assign rsp_tdata = head.out_char;
   assign rsp_tuser = {head.bad_format, head.char_present};
   assign rsp_tlast = head.string_done;

endmodule
